// ===== src/tcgm_pkg.sv =====
// Types, constants and lookup functions shared by the controller-to-gamepad mapper.
package tcgm_pkg;

   localparam logic [1:0] REG_TAP_WINDOW = 2'd0;
   localparam logic [1:0] REG_PLUS_PULSE = 2'd1;
   localparam logic [1:0] REG_NEUTRAL_Y  = 2'd2;

   localparam logic [3:0] HAT_UP     = 4'd0;
   localparam logic [3:0] HAT_RIGHT  = 4'd2;
   localparam logic [3:0] HAT_DOWN   = 4'd4;
   localparam logic [3:0] HAT_LEFT   = 4'd6;
   localparam logic [3:0] HAT_CENTER = 4'd8;

   localparam logic [13:0] PAD_Y    = 14'h0001;
   localparam logic [13:0] PAD_B    = 14'h0002;
   localparam logic [13:0] PAD_A    = 14'h0004;
   localparam logic [13:0] PAD_X    = 14'h0008;
   localparam logic [13:0] PAD_PLUS = 14'h0200;
   localparam logic [13:0] PAD_HOME = 14'h1000;

   localparam logic [3:0] POWER_INVALID = 4'hF;
   localparam logic [4:0] BRAKE_INVALID = 5'h1F;

   typedef struct packed {
      logic [15:0] tap_window_ms;
      logic [15:0] plus_pulse_ms;
      logic [7:0]  neutral_y;
   } cfg_type;

   typedef struct packed {
      logic        button_a;
      logic        button_b;
      logic        button_c;
      logic        button_start;
      logic        button_select;
      logic        button_home;
      logic [3:0]  power_notch;
      logic [4:0]  brake_notch;
      logic [31:0] now_ms;
   } poll_type;

   typedef struct packed {
      logic [13:0] pad_buttons;
      logic [3:0]  pad_hat;
      logic [7:0]  stick_y;
   } pad_report_type;

   // Brake notches above eight use the last entry.
   function automatic logic [7:0] brake_y(input logic [3:0] notch);
      logic [7:0] y;
      case (notch)
         4'd0: y = 8'd128;
         4'd1: y = 8'd96;
         4'd2: y = 8'd82;
         4'd3: y = 8'd68;
         4'd4: y = 8'd52;
         4'd5: y = 8'd38;
         4'd6: y = 8'd24;
         4'd7: y = 8'd18;
         4'd8: y = 8'd10;
         default: y = 8'd0;
      endcase
      return y;
   endfunction

   // 138 + 117 * power / 5, truncated toward zero and saturated, for every 4-bit notch.
   function automatic logic [7:0] power_y(input logic [3:0] notch);
      logic [7:0] y;
      case (notch)
         4'h8: y = 8'd0;
         4'h9: y = 8'd0;
         4'hA: y = 8'd0;
         4'hB: y = 8'd21;
         4'hC: y = 8'd45;
         4'hD: y = 8'd68;
         4'hE: y = 8'd92;
         4'hF: y = 8'd115;
         4'h0: y = 8'd138;
         4'h1: y = 8'd161;
         4'h2: y = 8'd184;
         4'h3: y = 8'd208;
         4'h4: y = 8'd231;
         default: y = 8'd255;
      endcase
      return y;
   endfunction

endpackage

// ===== src/tcgm_cfg.sv =====
// Configuration register bank behind the APB-style port.
module tcgm_cfg
   import tcgm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TAP_WINDOW: cfg_in.tap_window_ms = pwdata[15:0];
            REG_PLUS_PULSE: cfg_in.plus_pulse_ms = pwdata[15:0];
            REG_NEUTRAL_Y:  cfg_in.neutral_y     = pwdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_window_ms <= 16'd100;
         cfg_ff.plus_pulse_ms <= 16'd50;
         cfg_ff.neutral_y     <= 8'd128;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TAP_WINDOW: prdata = {16'd0, cfg_ff.tap_window_ms};
         REG_PLUS_PULSE: prdata = {16'd0, cfg_ff.plus_pulse_ms};
         REG_NEUTRAL_Y:  prdata = {24'd0, cfg_ff.neutral_y};
         default:        prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/tcgm_map.sv =====
// Mapping stage: controller state, report decision and the result register.
module tcgm_map
   import tcgm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           poll_valid,
   input  poll_type       poll,
   output logic           poll_take,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output pad_report_type report
);

   logic           held_ff, held_in;
   logic [31:0]    down_ff, down_in;
   logic           plus_act_ff, plus_act_in;
   logic [31:0]    plus_start_ff, plus_start_in;
   logic [6:0]     mask_ff, mask_in;
   logic [3:0]     power_ff, power_in;
   logic [4:0]     brake_ff, brake_in;
   logic           rsp_valid_ff, rsp_valid_in;
   pad_report_type report_ff, report_in;

   logic [31:0] sel_dt;
   logic [31:0] plus_dt;
   logic        tap;
   logic        long_hold;
   logic        plus_mid;
   logic [31:0] start_mid;
   logic        expire;
   logic        plus_end;
   logic [6:0]  mask;
   logic [3:0]  power_eff;
   logic [4:0]  brake_eff;
   logic        emit;
   logic        out_free;
   logic        advance;
   logic [3:0]  brake_idx;

   always_comb begin
      sel_dt    = poll.now_ms - down_ff;
      tap       = held_ff && !poll.button_select && (sel_dt <= {16'd0, cfg.tap_window_ms});
      long_hold = held_ff && poll.button_select && (sel_dt > {16'd0, cfg.tap_window_ms});
      plus_mid  = plus_act_ff || tap;
      start_mid = tap ? poll.now_ms : plus_start_ff;
      plus_dt   = poll.now_ms - start_mid;
      expire    = plus_mid && (plus_dt > {16'd0, cfg.plus_pulse_ms});
      plus_end  = plus_mid && !expire;
      mask      = {plus_mid, poll.button_home, poll.button_select, poll.button_start,
                   poll.button_c, poll.button_b, poll.button_a};
      power_eff = (poll.power_notch == POWER_INVALID) ? power_ff : poll.power_notch;
      brake_eff = (poll.brake_notch == BRAKE_INVALID) ? brake_ff : poll.brake_notch;
      emit      = (mask != mask_ff) || (power_eff != power_ff) || (brake_eff != brake_ff);
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = poll_valid && (!emit || out_free);
   end

   always_comb begin
      report_in.pad_buttons = 14'd0;
      report_in.pad_hat     = HAT_CENTER;
      if (long_hold) begin
         if (poll.button_start) begin
            report_in.pad_hat = HAT_UP;
         end else if (poll.button_c) begin
            report_in.pad_hat = HAT_RIGHT;
         end else if (poll.button_b) begin
            report_in.pad_hat = HAT_DOWN;
         end else if (poll.button_a) begin
            report_in.pad_hat = HAT_LEFT;
         end
      end else begin
         if (poll.button_a)     report_in.pad_buttons = report_in.pad_buttons | PAD_Y;
         if (poll.button_b)     report_in.pad_buttons = report_in.pad_buttons | PAD_B;
         if (poll.button_c)     report_in.pad_buttons = report_in.pad_buttons | PAD_A;
         if (poll.button_start) report_in.pad_buttons = report_in.pad_buttons | PAD_X;
      end
      if (poll.button_home) report_in.pad_buttons = report_in.pad_buttons | PAD_HOME;
      if (plus_end)         report_in.pad_buttons = report_in.pad_buttons | PAD_PLUS;

      brake_idx = brake_eff[3:0];
      if (!brake_eff[4] && (brake_eff != 5'd0)) begin
         report_in.stick_y = brake_y(brake_idx);
      end else begin
         report_in.stick_y = power_y(power_eff);
      end
      if ((brake_eff == 5'd0) && (power_eff == 4'd0)) begin
         report_in.stick_y = cfg.neutral_y;
      end
   end

   always_comb begin
      held_in       = held_ff;
      down_in       = down_ff;
      plus_act_in   = plus_act_ff;
      plus_start_in = plus_start_ff;
      mask_in       = mask_ff;
      power_in      = power_ff;
      brake_in      = brake_ff;
      if (advance) begin
         held_in       = poll.button_select;
         down_in       = poll.button_select ? (held_ff ? down_ff : poll.now_ms) : 32'd0;
         plus_act_in   = plus_end;
         plus_start_in = expire ? 32'd0 : start_mid;
         mask_in       = mask;
         power_in      = power_eff;
         brake_in      = brake_eff;
      end
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 1'b0;
         down_ff       <= 32'd0;
         plus_act_ff   <= 1'b0;
         plus_start_ff <= 32'd0;
         mask_ff       <= 7'd0;
         power_ff      <= POWER_INVALID;
         brake_ff      <= BRAKE_INVALID;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_ff       <= held_in;
         down_ff       <= down_in;
         plus_act_ff   <= plus_act_in;
         plus_start_ff <= plus_start_in;
         mask_ff       <= mask_in;
         power_ff      <= power_in;
         brake_ff      <= brake_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         report_ff <= report_in;
      end
   end

   assign poll_take = advance;
   assign rsp_valid = rsp_valid_ff;
   assign report    = report_ff;

endmodule

// ===== src/train_controller_to_gamepad_mapper_top.sv =====
// Top level of the train controller to gamepad report mapper.
// A report passes through the input register and then the result register.
// Throughput: one item per cycle; an item that causes a report waits while a report is stalled.
// An item that causes no report still moves through the input register without waiting on a stalled report.
// Reset is synchronous: it clears the controller state, empties both registers and
// restores the configuration registers to their documented values.
module train_controller_to_gamepad_mapper_top
   import tcgm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_button_a,
   input  logic        req_button_b,
   input  logic        req_button_c,
   input  logic        req_button_start,
   input  logic        req_button_select,
   input  logic        req_button_home,
   input  logic [3:0]  req_power_notch,
   input  logic [4:0]  req_brake_notch,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [13:0] rsp_pad_buttons,
   output logic [3:0]  rsp_pad_hat,
   output logic [7:0]  rsp_stick_y,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type        cfg;
   poll_type       poll_ff;
   logic           poll_valid_ff, poll_valid_in;
   logic           poll_take;
   logic           req_load;
   pad_report_type report;

   tcgm_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_stall = poll_valid_ff && !poll_take;
   assign req_load  = req_valid && !req_stall;

   always_comb begin
      if (req_load) begin
         poll_valid_in = 1'b1;
      end else if (poll_take) begin
         poll_valid_in = 1'b0;
      end else begin
         poll_valid_in = poll_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
      end else begin
         poll_valid_ff <= poll_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         poll_ff.button_a      <= req_button_a;
         poll_ff.button_b      <= req_button_b;
         poll_ff.button_c      <= req_button_c;
         poll_ff.button_start  <= req_button_start;
         poll_ff.button_select <= req_button_select;
         poll_ff.button_home   <= req_button_home;
         poll_ff.power_notch   <= req_power_notch;
         poll_ff.brake_notch   <= req_brake_notch;
         poll_ff.now_ms        <= req_now_ms;
      end
   end

   tcgm_map u_map (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .poll_valid (poll_valid_ff),
      .poll       (poll_ff),
      .poll_take  (poll_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .report     (report)
   );

   assign rsp_pad_buttons = report.pad_buttons;
   assign rsp_pad_hat     = report.pad_hat;
   assign rsp_stick_y     = report.stick_y;

endmodule
